@@ hw/rtl/tchl_pkg.sv @@
// Shared constants for the luma tone curve block: fixed-point coefficients and
// configuration register indexes. No dependencies.
package tchl_pkg;

    // Rec.709 luma weights, Q0.16, summing to 65536.
    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;

    // Rounding offset for the luma sum.
    localparam logic [15:0] LUMA_ROUND = 16'd32768;

    // Blend weight 0.65 in Q0.16.
    localparam logic [15:0] BLEND_K = 16'd42598;

    // 1.0 in Q1.15.
    localparam logic [15:0] ONE15 = 16'd32768;

    // Configuration register indexes.
    localparam logic [2:0] REG_POINT_COUNT = 3'd0;
    localparam logic [2:0] REG_POINT_FIRST = 3'd1;

endpackage

@@ hw/rtl/tone_curve_hermite_luma.sv @@
// Luma tone curve: Rec.709 luma, cubic Hermite curve, blend and channel rescale.
// Depends on tchl_pkg for coefficients and register indexes.
//
// Usage:
//   Pixels enter on the in_valid/in_ready channel (red_in, green_in, blue_in)
//   and leave on the out_valid/out_ready channel (red_out, green_out, blue_out),
//   one result per input transaction, in order.
//   The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the point
//   count (index 0) and the control points (index 1 upwards); cfg_ready is
//   always high. The user must make writes only while the pipeline is empty, which the block does not enforce.
//   The datapath is a single pipeline of CHANNEL_BITS + 30 register stages
//   (46 at the default width). One pixel is taken every cycle while the
//   receiver does not stall.
//   The depth is set by the two long divisions, 16 stages for the segment
//   parameter and CHANNEL_BITS stages for the channel rescale, one bit each.
//   Reset clears the stage valid bits and every configuration register, so the
//   block starts in pass-through with no points.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready falls; nothing is dropped or repeated.
module tone_curve_hermite_luma #(
    parameter int MAX_POINTS   = 7,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] red_out,
    output logic [CHANNEL_BITS-1:0] green_out,
    output logic [CHANNEL_BITS-1:0] blue_out,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [63:0]             cfg_data
);

    localparam int CB        = CHANNEL_BITS;
    localparam int CH_FRAC   = CB - 1;
    localparam int CURVE_SHR = (CH_FRAC > 15) ? CH_FRAC - 15 : 0;
    localparam int CURVE_SHL = (CH_FRAC < 15) ? 15 - CH_FRAC : 0;
    localparam int PW        = CB + 16;
    localparam int NW        = 2 * CB + 1;

    // Stage positions along the pipeline.
    localparam int V_S1  = 0;
    localparam int V_S2  = 1;
    localparam int V_S3  = 2;
    localparam int V_DVE = V_S3 + 16;
    localparam int V_T2  = V_DVE + 1;
    localparam int V_T3  = V_T2 + 1;
    localparam int V_H   = V_T3 + 1;
    localparam int V_PP  = V_H + 1;
    localparam int V_PR  = V_PP + 1;
    localparam int V_ACC = V_PR + 1;
    localparam int V_BL  = V_ACC + 1;
    localparam int V_N   = V_BL + 1;
    localparam int V_NUM = V_N + 1;
    localparam int V_OD0 = V_NUM + 1;
    localparam int V_ODE = V_OD0 + CB;
    localparam int V_OUT = V_ODE + 1;
    localparam int NST   = V_OUT + 1;

    typedef struct packed {
        logic          bypass;
        logic          zero;
        logic          direct;
        logic [15:0]   ydir;
        logic [CB-1:0] c0;
        logic [CB-1:0] c1;
        logic [CB-1:0] c2;
        logic [CB-1:0] lum;
    } side_t;

    typedef struct packed {
        logic [15:0]        yi;
        logic [15:0]        yi1;
        logic signed [31:0] mi;
        logic signed [31:0] mi1;
        logic [15:0]        dx;
    } cv_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]  cnt_reg;
    logic [63:0] pts_reg [MAX_POINTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                pts_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tchl_pkg::REG_POINT_COUNT)
            begin
                cnt_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (cfg_index == 3'(tchl_pkg::REG_POINT_FIRST + 3'(i)))
                begin
                    pts_reg[i] <= cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic           en;

    assign en        = !vld_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[V_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: luma products
    // ------------------------------------------------------------------
    logic [PW-1:0] s1_pr_reg, s1_pg_reg, s1_pb_reg;
    logic [CB-1:0] s1_c0_reg, s1_c1_reg, s1_c2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pr_reg <= PW'(red_in) * PW'(tchl_pkg::LUMA_R);
            s1_pg_reg <= PW'(green_in) * PW'(tchl_pkg::LUMA_G);
            s1_pb_reg <= PW'(blue_in) * PW'(tchl_pkg::LUMA_B);
            s1_c0_reg <= red_in;
            s1_c1_reg <= green_in;
            s1_c2_reg <= blue_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: luma sum and curve input
    // ------------------------------------------------------------------
    logic [PW+1:0] s2_sum;
    logic [CB-1:0] s2_lum;
    logic [CB-1:0] s2_lum_reg;
    logic [15:0]   s2_x_reg;
    logic [CB-1:0] s2_c0_reg, s2_c1_reg, s2_c2_reg;

    assign s2_sum = (PW+2)'(s1_pr_reg) + (PW+2)'(s1_pg_reg) + (PW+2)'(s1_pb_reg)
                  + (PW+2)'(tchl_pkg::LUMA_ROUND);
    assign s2_lum = s2_sum[CB+15:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_lum_reg <= s2_lum;
            s2_x_reg   <= 16'((32'(s2_lum) >> CURVE_SHR) << CURVE_SHL);
            s2_c0_reg  <= s1_c0_reg;
            s2_c1_reg  <= s1_c1_reg;
            s2_c2_reg  <= s1_c2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: segment search and special cases
    // ------------------------------------------------------------------
    side_t sd_reg [V_S3:V_ODE];
    cv_t   cv_reg [V_S3:V_H];
    logic [15:0] rem_reg [V_S3:V_DVE];
    logic [15:0] q_reg   [V_S3:V_DVE];

    logic [2:0]         n_eff, n_m1, idx;
    logic [15:0]        px [MAX_POINTS];
    logic [15:0]        py [MAX_POINTS];
    logic signed [31:0] pm [MAX_POINTS];
    logic [15:0]        xl, yl, xi, xi1, yi, yi1;
    logic signed [31:0] mi, mi1;
    logic [16:0]        dx17;
    logic               s3_direct;
    logic [15:0]        s3_y, s3_yc, s3_tn;

    always_comb
    begin
        n_eff = (cnt_reg > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : cnt_reg;
        n_m1  = n_eff - 3'd1;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            px[i] = pts_reg[i][15:0];
            py[i] = pts_reg[i][31:16];
            pm[i] = $signed(pts_reg[i][63:32]);
        end
        xl = px[0];
        yl = py[0];
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (n_m1 == 3'(i))
            begin
                xl = px[i];
                yl = py[i];
            end
        end
        // First segment whose right end lies above x.
        idx = '0;
        for (int i = MAX_POINTS - 2; i >= 0; i--)
        begin
            if ((3'(i + 2) <= n_eff) && (s2_x_reg < px[i+1]))
            begin
                idx = 3'(i);
            end
        end
        xi  = px[0];
        xi1 = px[1];
        yi  = py[0];
        yi1 = py[1];
        mi  = pm[0];
        mi1 = pm[1];
        for (int i = 0; i < MAX_POINTS - 1; i++)
        begin
            if (idx == 3'(i))
            begin
                xi  = px[i];
                xi1 = px[i+1];
                yi  = py[i];
                yi1 = py[i+1];
                mi  = pm[i];
                mi1 = pm[i+1];
            end
        end
        dx17 = {1'b0, xi1} - {1'b0, xi};

        s3_direct = 1'b1;
        if ((n_eff == 3'd1) || (s2_x_reg <= px[0]))
        begin
            s3_y = py[0];
        end
        else if (s2_x_reg >= xl)
        begin
            s3_y = yl;
        end
        else if (dx17[16] || (dx17 == 17'd0))
        begin
            s3_y = yi;
        end
        else
        begin
            s3_y      = yi;
            s3_direct = 1'b0;
        end
        s3_yc = (s3_y > tchl_pkg::ONE15) ? tchl_pkg::ONE15 : s3_y;
        s3_tn = (s2_x_reg >= xi) ? (s2_x_reg - xi) : 16'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[V_S3].bypass <= (n_eff == 3'd0);
            sd_reg[V_S3].zero   <= (s2_lum_reg == '0);
            sd_reg[V_S3].direct <= s3_direct;
            sd_reg[V_S3].ydir   <= s3_yc;
            sd_reg[V_S3].c0     <= s2_c0_reg;
            sd_reg[V_S3].c1     <= s2_c1_reg;
            sd_reg[V_S3].c2     <= s2_c2_reg;
            sd_reg[V_S3].lum    <= s2_lum_reg;
            cv_reg[V_S3].yi     <= yi;
            cv_reg[V_S3].yi1    <= yi1;
            cv_reg[V_S3].mi     <= mi;
            cv_reg[V_S3].mi1    <= mi1;
            cv_reg[V_S3].dx     <= dx17[15:0];
            rem_reg[V_S3]       <= s3_tn;
            q_reg[V_S3]         <= '0;
        end
    end

    // Side data and segment data ride along with their pixel.
    for (genvar p = V_S3; p < V_ODE; p++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_reg[p+1] <= sd_reg[p];
            end
        end
    end

    for (genvar p = V_S3; p < V_H; p++)
    begin : g_cv
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cv_reg[p+1] <= cv_reg[p];
            end
        end
    end

    // ------------------------------------------------------------------
    // Segment parameter t = (x - xi) * 65536 / dx, one quotient bit a stage.
    // The numerator is below dx, so the quotient fits 16 bits.
    // ------------------------------------------------------------------
    for (genvar p = V_S3; p < V_DVE; p++)
    begin : g_tdiv
        logic [16:0] trial;
        logic        ge;

        assign trial = {rem_reg[p], 1'b0};
        assign ge    = (trial >= {1'b0, cv_reg[p].dx});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[p+1] <= ge ? 16'(trial - {1'b0, cv_reg[p].dx}) : trial[15:0];
                q_reg[p+1]   <= {q_reg[p][14:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // t^2 and slope products
    // ------------------------------------------------------------------
    logic [15:0]        t2s_t_reg, t2_reg;
    logic [31:0]        dml0_reg, dml1_reg;
    logic signed [32:0] dmh0_reg, dmh1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2s_t_reg <= q_reg[V_DVE];
            t2_reg    <= 16'((32'(q_reg[V_DVE]) * 32'(q_reg[V_DVE])) >> 16);
            dml0_reg  <= 32'(cv_reg[V_DVE].dx) * 32'(cv_reg[V_DVE].mi[15:0]);
            dml1_reg  <= 32'(cv_reg[V_DVE].dx) * 32'(cv_reg[V_DVE].mi1[15:0]);
            dmh0_reg  <= 33'($signed({1'b0, cv_reg[V_DVE].dx}))
                       * 33'($signed(cv_reg[V_DVE].mi[31:16]));
            dmh1_reg  <= 33'($signed({1'b0, cv_reg[V_DVE].dx}))
                       * 33'($signed(cv_reg[V_DVE].mi1[31:16]));
        end
    end

    // ------------------------------------------------------------------
    // t^3 and full slope terms dx * m
    // ------------------------------------------------------------------
    logic [15:0]        t3s_t_reg, t3s_t2_reg, t3_reg;
    logic signed [48:0] dm0_reg, dm1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3s_t_reg  <= t2s_t_reg;
            t3s_t2_reg <= t2_reg;
            t3_reg     <= 16'((32'(t2_reg) * 32'(t2s_t_reg)) >> 16);
            dm0_reg    <= (49'(dmh0_reg) <<< 16) + $signed({17'b0, dml0_reg});
            dm1_reg    <= (49'(dmh1_reg) <<< 16) + $signed({17'b0, dml1_reg});
        end
    end

    // ------------------------------------------------------------------
    // Hermite basis
    // ------------------------------------------------------------------
    logic signed [19:0] st, st2, st3;
    logic signed [19:0] h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [48:0] hdm0_reg, hdm1_reg;

    assign st  = $signed({4'b0, t3s_t_reg});
    assign st2 = $signed({4'b0, t3s_t2_reg});
    assign st3 = $signed({4'b0, t3_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h00_reg  <= (st3 <<< 1) - 20'sd3 * st2 + 20'sd65536;
            h10_reg  <= st3 - (st2 <<< 1) + st;
            h01_reg  <= 20'sd3 * st2 - (st3 <<< 1);
            h11_reg  <= st3 - st2;
            hdm0_reg <= dm0_reg;
            hdm1_reg <= dm1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Partial products; the slope terms are split into a low 24-bit and a high 25-bit half.
    // ------------------------------------------------------------------
    logic signed [44:0] p10l_reg, p10h_reg, p11l_reg, p11h_reg;
    logic signed [36:0] p00_reg, p01_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p10l_reg <= 45'(h10_reg) * 45'($signed({1'b0, hdm0_reg[23:0]}));
            p10h_reg <= 45'(h10_reg) * 45'($signed(hdm0_reg[48:24]));
            p11l_reg <= 45'(h11_reg) * 45'($signed({1'b0, hdm1_reg[23:0]}));
            p11h_reg <= 45'(h11_reg) * 45'($signed(hdm1_reg[48:24]));
            p00_reg  <= 37'(h00_reg) * 37'($signed({1'b0, cv_reg[V_H].yi}));
            p01_reg  <= 37'(h01_reg) * 37'($signed({1'b0, cv_reg[V_H].yi1}));
        end
    end

    // ------------------------------------------------------------------
    // Recombine slope terms and floor them to Q31
    // ------------------------------------------------------------------
    logic signed [68:0] full10, full11;
    logic signed [52:0] f10_reg, f11_reg;
    logic signed [36:0] q00_reg, q01_reg;

    assign full10 = (69'(p10h_reg) <<< 24) + 69'(p10l_reg);
    assign full11 = (69'(p11h_reg) <<< 24) + 69'(p11l_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f10_reg <= 53'(full10 >>> 16);
            f11_reg <= 53'(full11 >>> 16);
            q00_reg <= p00_reg;
            q01_reg <= p01_reg;
        end
    end

    // ------------------------------------------------------------------
    // Curve sum, floor to Q1.15 and clamp
    // ------------------------------------------------------------------
    logic signed [55:0] acc;
    logic signed [39:0] acc15;
    logic [15:0]        acc_c;
    logic [15:0]        cv15_reg;

    assign acc   = 56'(f10_reg) + 56'(f11_reg) + 56'(q00_reg) + 56'(q01_reg);
    assign acc15 = 40'(acc >>> 16);

    always_comb
    begin
        if (acc15 < 40'sd0)
        begin
            acc_c = '0;
        end
        else if (acc15 > $signed({24'b0, tchl_pkg::ONE15}))
        begin
            acc_c = tchl_pkg::ONE15;
        end
        else
        begin
            acc_c = acc15[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cv15_reg <= sd_reg[V_PR].direct ? sd_reg[V_PR].ydir : acc_c;
        end
    end

    // ------------------------------------------------------------------
    // Blend 65% toward the mapped luma
    // ------------------------------------------------------------------
    logic [CB-1:0]        mapped;
    logic signed [CB:0]   diff;
    logic signed [CB+17:0] prod_reg;

    assign mapped = CB'((32'(cv15_reg) << CURVE_SHR) >> CURVE_SHL);
    assign diff   = $signed({1'b0, mapped}) - $signed({1'b0, sd_reg[V_ACC].lum});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (CB+18)'(diff) * (CB+18)'($signed({1'b0, tchl_pkg::BLEND_K}));
        end
    end

    logic signed [CB+1:0] nl;
    logic [CB-1:0]        n_reg;

    assign nl = (CB+2)'($signed({1'b0, sd_reg[V_BL].lum})) + (CB+2)'(prod_reg >>> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= nl[CB+1] ? '0 : nl[CB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Rescale numerators c * N + L/2
    // ------------------------------------------------------------------
    logic [NW-1:0] num_reg [3];
    logic [CB-1:0] cin [3];

    assign cin[0] = sd_reg[V_N].c0;
    assign cin[1] = sd_reg[V_N].c1;
    assign cin[2] = sd_reg[V_N].c2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= NW'(cin[k]) * NW'(n_reg) + NW'(sd_reg[V_N].lum >> 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Rescale division by luma, one quotient bit a stage. A numerator at or
    // above L * 2^CB saturates straight away.
    // ------------------------------------------------------------------
    logic [CB-1:0] od_rem_reg [V_OD0:V_ODE][3];
    logic [CB-1:0] od_lo_reg  [V_OD0:V_ODE][3];
    logic [CB-1:0] od_q_reg   [V_OD0:V_ODE][3];
    logic          od_sat_reg [V_OD0:V_ODE][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                od_sat_reg[V_OD0][k] <= (num_reg[k] >= {1'b0, sd_reg[V_NUM].lum, {CB{1'b0}}});
                od_rem_reg[V_OD0][k] <= num_reg[k][2*CB-1:CB];
                od_lo_reg[V_OD0][k]  <= num_reg[k][CB-1:0];
                od_q_reg[V_OD0][k]   <= '0;
            end
        end
    end

    for (genvar p = V_OD0; p < V_ODE; p++)
    begin : g_odiv
        for (genvar k = 0; k < 3; k++)
        begin : g_ch
            logic [CB:0] trial;
            logic        ge;

            assign trial = {od_rem_reg[p][k], od_lo_reg[p][k][CB-1]};
            assign ge    = (trial >= {1'b0, sd_reg[p].lum});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    od_rem_reg[p+1][k] <= ge ? CB'(trial - {1'b0, sd_reg[p].lum})
                                             : trial[CB-1:0];
                    od_lo_reg[p+1][k]  <= od_lo_reg[p][k] << 1;
                    od_q_reg[p+1][k]   <= {od_q_reg[p][k][CB-2:0], ge};
                    od_sat_reg[p+1][k] <= od_sat_reg[p][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [CB-1:0] out_reg [3];
    logic [CB-1:0] cfin [3];

    assign cfin[0] = sd_reg[V_ODE].c0;
    assign cfin[1] = sd_reg[V_ODE].c1;
    assign cfin[2] = sd_reg[V_ODE].c2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (sd_reg[V_ODE].bypass)
                begin
                    out_reg[k] <= cfin[k];
                end
                else if (sd_reg[V_ODE].zero)
                begin
                    out_reg[k] <= '0;
                end
                else if (od_sat_reg[V_ODE][k])
                begin
                    out_reg[k] <= {CB{1'b1}};
                end
                else
                begin
                    out_reg[k] <= od_q_reg[V_ODE][k];
                end
            end
        end
    end

    assign red_out   = out_reg[0];
    assign green_out = out_reg[1];
    assign blue_out  = out_reg[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_follows_sink: assert property (
        @(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("input stalled while the sink is ready");

    a_stall_freezes_pipe: assert property (
        @(posedge clk) disable iff (!rst_n) !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_curve_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        vld_reg[V_ACC] |-> (cv15_reg <= tchl_pkg::ONE15))
        else $error("curve value above 1.0");

endmodule

@@ tb/sv/tb_tone_curve_hermite_luma.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the luma tone curve block: random and directed pixels,
// several curve settings, and an in-line predictor of the expected colours.
// Depends on tone_curve_hermite_luma and tchl_pkg.
module tb_tone_curve_hermite_luma;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    localparam int PIPE_DEPTH  = 46;
    localparam int STALL_LIMIT = 5000;

    pixel_t      expected_pixels[$];
    logic [2:0]  curve_points;
    logic [63:0] curve_regs[7];
    int          error_count;
    int          pixels_sent;
    int          pixels_checked;
    int          idle_cycles;
    bit          back_pressure;

    tone_curve_hermite_luma dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_unit(longint y);
        if (y < 0)
            return 0;
        if (y > 32768)
            return 32768;
        return y;
    endfunction

    function automatic longint point_x(int i);
        return longint'(curve_regs[i][15:0]);
    endfunction

    function automatic longint point_y(int i);
        return longint'(curve_regs[i][31:16]);
    endfunction

    function automatic longint point_slope(int i);
        return longint'($signed(curve_regs[i][63:32]));
    endfunction

    function automatic longint hermite_map(longint x, int n);
        int     seg;
        longint dx;
        longint t;
        longint t2;
        longint t3;
        longint acc;
        seg = 0;
        if (n == 1 || x <= point_x(0))
            return clamp_unit(point_y(0));
        if (x >= point_x(n - 1))
            return clamp_unit(point_y(n - 1));
        for (int i = n - 2; i >= 0; i--)
            if (x < point_x(i + 1))
                seg = i;
        dx = point_x(seg + 1) - point_x(seg);
        if (dx <= 0)
            return clamp_unit(point_y(seg));
        t = x - point_x(seg);
        if (t < 0)
            t = 0;
        t = (t << 16) / dx;
        if (t > 65535)
            t = 65535;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        acc = (2 * t3 - 3 * t2 + 65536) * point_y(seg) + (3 * t2 - 2 * t3) * point_y(seg + 1)
            + floor_shr((t3 - 2 * t2 + t) * (dx * point_slope(seg)), 16)
            + floor_shr((t3 - t2) * (dx * point_slope(seg + 1)), 16);
        return clamp_unit(floor_shr(acc, 16));
    endfunction

    function automatic pixel_t toned_pixel(pixel_t p);
        pixel_t     r;
        longint     lum;
        longint     nl;
        longint     v;
        longint     c[3];
        c[0] = p.red;
        c[1] = p.green;
        c[2] = p.blue;
        if (curve_points == 0)
            return p;
        lum = (13933 * c[0] + 46871 * c[1] + 4732 * c[2] + 32768) >> 16;
        if (lum == 0)
            return '0;
        nl = lum + floor_shr((hermite_map(lum, int'(curve_points)) - lum) * 42598, 16);
        if (nl < 0)
            nl = 0;
        for (int k = 0; k < 3; k++)
        begin
            v = (c[k] * nl + lum / 2) / lum;
            if (v > 65535)
                v = 65535;
            c[k] = v;
        end
        r.red = c[0][15:0];
        r.green = c[1][15:0];
        r.blue = c[2][15:0];
        return r;
    endfunction

    // Gap lengths: mostly none or short, now and then long.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // With no gap the next transaction follows at once and valid stays high.
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        pixel_t p;
        int     gap;
        p = '{r, g, b};
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_pixels = {expected_pixels, toned_pixel(p)};
        pixels_sent++;
        @(negedge clk);
        gap = random_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
    endtask

    task automatic send_random_pixel();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            send_pixel(16'($urandom_range(3)), 16'($urandom_range(3)),
                       16'($urandom_range(3)));
        else if (roll < 7)
            send_pixel(16'($urandom_range(32768)), 16'($urandom_range(32768)),
                       16'($urandom_range(32768)));
        else
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4)
            @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] index, logic [63:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == tchl_pkg::REG_POINT_COUNT)
            curve_points = value[2:0];
        else
            curve_regs[index - tchl_pkg::REG_POINT_FIRST] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [63:0] pack_point(int x, int y, int slope);
        return {slope[31:0], y[15:0], x[15:0]};
    endfunction

    // A curve over n points with sorted x, random y and modest slopes.
    task automatic load_sorted_curve(int n);
        int xs[7];
        drain_pipeline();
        for (int i = 0; i < 7; i++)
            xs[i] = $urandom_range(65535);
        xs.sort();
        for (int i = 0; i < 7; i++)
            write_register(3'(tchl_pkg::REG_POINT_FIRST + 3'(i)),
                           pack_point(xs[i], $urandom_range(40000),
                                      int'($urandom_range(196608)) - 65536));
        write_register(tchl_pkg::REG_POINT_COUNT, 64'(n));
    endtask

    task automatic test_pass_through();
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'h8000, 16'h0001, 16'h7fff);
        send_pixel(16'h5555, 16'haaaa, 16'h0f0f);
    endtask

    task automatic test_single_point();
        drain_pipeline();
        write_register(tchl_pkg::REG_POINT_FIRST, pack_point(16000, 30000, 0));
        write_register(tchl_pkg::REG_POINT_COUNT, 64'd1);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'hffff, 16'h0000, 16'h0000);
        // A y above one must be clamped.
        drain_pipeline();
        write_register(tchl_pkg::REG_POINT_FIRST, 64'hffff_ffff_ffff_0000);
        send_pixel(16'h4000, 16'h4000, 16'h4000);
        send_pixel(16'h0000, 16'h0000, 16'hffff);
    endtask

    task automatic test_edge_points();
        drain_pipeline();
        write_register(tchl_pkg::REG_POINT_FIRST, pack_point(8192, 4000, 65536));
        write_register(tchl_pkg::REG_POINT_FIRST + 3'd1, pack_point(8192, 9000, -65536));
        write_register(tchl_pkg::REG_POINT_FIRST + 3'd2, pack_point(4000, 20000, 200000));
        write_register(tchl_pkg::REG_POINT_FIRST + 3'd3, pack_point(24576, 32768, 0));
        write_register(tchl_pkg::REG_POINT_FIRST + 3'd4,
                       pack_point(30000, 40000, 32'h7fffffff));
        write_register(tchl_pkg::REG_POINT_FIRST + 3'd5, pack_point(40000, 0, 32'h80000000));
        write_register(tchl_pkg::REG_POINT_FIRST + 3'd6, pack_point(65535, 65535, -1));
        write_register(tchl_pkg::REG_POINT_COUNT, 64'd7);
        // Left of the first point, equal x, unsorted point, interior and right end.
        send_pixel(16'h1000, 16'h1000, 16'h1000);
        send_pixel(16'h2000, 16'h2000, 16'h2000);
        send_pixel(16'h3000, 16'h3000, 16'h3000);
        send_pixel(16'h7000, 16'h7000, 16'h7000);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'hffff, 16'h0000, 16'hffff);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_curves();
        for (int phase = 0; phase < 16; phase++)
        begin
            load_sorted_curve(phase % 8);
            back_pressure = (phase % 3 == 1);
            for (int i = 0; i < 80; i++)
                send_random_pixel();
            if (phase == 5)
                drain_pipeline();
        end
        back_pressure = 1'b0;
    endtask

    task automatic test_random_registers();
        drain_pipeline();
        for (int i = 0; i < 7; i++)
            write_register(3'(tchl_pkg::REG_POINT_FIRST + 3'(i)), {$urandom, $urandom});
        write_register(tchl_pkg::REG_POINT_COUNT, 64'd7);
        for (int i = 0; i < 60; i++)
            send_random_pixel();
    endtask

    // Receiver: random stalls, heavier while back pressure is requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (back_pressure)
                out_ready <= ($urandom_range(3) == 0);
            else if ($urandom_range(99) < 8)
                out_ready <= 1'b0;
            else if ($urandom_range(99) < 3)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(30, 5))
                    @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("Result transaction with no pixel outstanding");
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (red_out !== want.red)
                begin
                    $error("red_out expected %0d actual %0d", want.red, red_out);
                    error_count++;
                end
                if (green_out !== want.green)
                begin
                    $error("green_out expected %0d actual %0d", want.green, green_out);
                    error_count++;
                end
                if (blue_out !== want.blue)
                begin
                    $error("blue_out expected %0d actual %0d", want.blue, blue_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        back_pressure = 1'b0;
        pixels_sent = 0;
        curve_points = '0;
        for (int i = 0; i < 7; i++)
            curve_regs[i] = '0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_pass_through();
        test_single_point();
        test_edge_points();
        test_random_curves();
        test_random_registers();
        drain_pipeline();
        $display("Checked %0d of %0d pixels over pass-through, single-point and", pixels_checked,
                 pixels_sent);
        $display("seven-point curves, including unsorted and random register contents.");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
